// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/mfb_pkg.sv =====
package mfb_pkg;

    // Framebuffer geometry
    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT + 7) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    // Field widths
    localparam int COORD_W = 10;
    localparam int LIN_W   = 2 * COORD_W;
    localparam int CNT_W   = 19;

    // Command codes
    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_RECT  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_ROTATION = 2'd2;

    // Register reset values
    localparam logic [COORD_W-1:0] WIDTH_RESET  = 10'd296;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 10'd128;

    localparam logic [7:0] PIX_MSB_MASK = 8'h80;
    localparam logic [7:0] BYTE_ONES    = 8'hFF;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic advance;
        logic pix_rd;
        logic pix_wr;
        logic byte_rd;
        logic out_load;
    } mfb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic s2_valid;
    } mfb_stat_t;

endpackage

// ===== sv/mono_framebuffer_plotter.sv =====
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | command, pos_x, pos_y, rect_width, rect_height,
//         |                        | ink, byte_address
// out     | out_valid / out_ready  | read_data, pixels_painted
// cfg     | cfg_write_en           | cfg_index, cfg_data
//
// A pixel or rectangle is taken, primes the map and address stages, then walks P pixels,
// each a read then a write of one byte on the single store port, before its result is
// given; a byte read gives it after one store read. in_ready rises together with out_valid.
// After reset the store is swept to zero with in_ready low.
// Results sit in an output register, so the next item is taken while one waits;
// a stalled result holds the block in its final state until it is taken.
module mono_framebuffer_plotter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [10:0]        rect_width,
    input  logic [10:0]        rect_height,
    input  logic               ink,
    input  logic [14:0]        byte_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         read_data,
    output logic [18:0]        pixels_painted
);
    import mfb_pkg::*;

    mfb_cmd_t  cmd;
    mfb_stat_t stat;

    mfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mfb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .rect_width     (rect_width),
        .rect_height    (rect_height),
        .ink            (ink),
        .byte_address   (byte_address),
        .cmd            (cmd),
        .stat           (stat),
        .read_data      (read_data),
        .pixels_painted (pixels_painted)
    );

endmodule

// ===== sv/mfb_ctrl.sv =====
module mfb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    output logic              out_valid,
    input  logic              out_ready,
    input  mfb_pkg::mfb_stat_t stat,
    output mfb_pkg::mfb_cmd_t  cmd
);
    import mfb_pkg::*;

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_PRIME_A = 3'd2;
    localparam logic [2:0] ST_PRIME_B = 3'd3;
    localparam logic [2:0] ST_PIX_RD  = 3'd4;
    localparam logic [2:0] ST_PIX_WR  = 3'd5;
    localparam logic [2:0] ST_BYTE_RD = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Sequence the clear pass, the pixel walk, the byte read and the result hand-off
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (command)
                        CMD_PIXEL: state_next = ST_PRIME_A;
                        CMD_RECT:  state_next = ST_PRIME_A;
                        CMD_READ:  state_next = ST_BYTE_RD;
                        default:   state_next = ST_FINISH;
                    endcase
                end
            end
            ST_PRIME_A:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_PRIME_B;
            end
            ST_PRIME_B:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_PIX_RD;
            end
            ST_PIX_RD:
            begin
                if (stat.s2_valid)
                begin
                    cmd.pix_rd = 1'b1;
                    state_next = ST_PIX_WR;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_PIX_WR:
            begin
                cmd.pix_wr  = 1'b1;
                cmd.advance = 1'b1;
                state_next  = ST_PIX_RD;
            end
            ST_BYTE_RD:
            begin
                cmd.byte_rd = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== sv/mfb_datapath.sv =====
module mfb_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [1:0]           cfg_index,
    input  logic [9:0]           cfg_data,
    input  logic [1:0]           command,
    input  logic signed [15:0]   pos_x,
    input  logic signed [15:0]   pos_y,
    input  logic [10:0]          rect_width,
    input  logic [10:0]          rect_height,
    input  logic                 ink,
    input  logic [14:0]          byte_address,
    input  mfb_pkg::mfb_cmd_t    cmd,
    output mfb_pkg::mfb_stat_t   stat,
    output logic [7:0]           read_data,
    output logic [18:0]          pixels_painted
);
    import mfb_pkg::*;

    // Configuration
    logic [COORD_W-1:0] width_reg, height_reg;
    logic [1:0]         rotation_reg;

    // Clear pass
    logic [ADDR_W-1:0]  clr_cnt_reg;

    // Latched item
    logic [1:0]         cmd_reg;
    logic               ink_reg;
    logic [ADDR_W-1:0]  addr_reg;

    // Walker bounds and position
    logic [COORD_W-1:0] x0_reg, x_last_reg, y_last_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic               walk_v_reg;

    // Map stage
    logic [COORD_W-1:0] nx_reg, ny_reg;
    logic               s1_v_reg;

    // Address stage
    logic [ADDR_W-1:0]  s2_idx_reg;
    logic [7:0]         s2_mask_reg;
    logic               s2_ok_reg;
    logic               s2_v_reg;

    logic [7:0]         rdata_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [7:0]         out_data_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic [7:0]         mem [0:STORE_BYTES-1];

    // Rotated logical size
    logic [COORD_W-1:0] lw, lh;
    assign lw = rotation_reg[0] ? height_reg : width_reg;
    assign lh = rotation_reg[0] ? width_reg : height_reg;

    // Clip the rectangle against the logical size; a pixel is a 1 by 1 rectangle
    logic [10:0]        eff_w, eff_h;
    logic signed [17:0] xe, ye, x0s, y0s, lws, lhs, x1s, y1s;
    logic               nonempty;
    always_comb
    begin
        eff_w    = (command == CMD_PIXEL) ? 11'd1 : rect_width;
        eff_h    = (command == CMD_PIXEL) ? 11'd1 : rect_height;
        xe       = 18'(pos_x) + $signed({7'd0, eff_w});
        ye       = 18'(pos_y) + $signed({7'd0, eff_h});
        x0s      = pos_x[15] ? 18'sd0 : 18'(pos_x);
        y0s      = pos_y[15] ? 18'sd0 : 18'(pos_y);
        lws      = $signed({8'd0, lw});
        lhs      = $signed({8'd0, lh});
        x1s      = (xe > lws) ? lws : xe;
        y1s      = (ye > lhs) ? lhs : ye;
        nonempty = (x0s < xe) && (x0s < lws) && (y0s < ye) && (y0s < lhs);
    end

    // Map logical to native coordinates
    logic [COORD_W-1:0] nx_next, ny_next;
    always_comb
    begin
        case (rotation_reg)
            2'd1:
            begin
                nx_next = width_reg - 10'd1 - py_reg;
                ny_next = px_reg;
            end
            2'd2:
            begin
                nx_next = width_reg - 10'd1 - px_reg;
                ny_next = height_reg - 10'd1 - py_reg;
            end
            2'd3:
            begin
                nx_next = py_reg;
                ny_next = height_reg - 10'd1 - px_reg;
            end
            default:
            begin
                nx_next = px_reg;
                ny_next = py_reg;
            end
        endcase
    end

    // Linear bit index, byte index and bit mask
    logic [LIN_W-1:0] lin;
    assign lin = LIN_W'(ny_reg) * LIN_W'(width_reg) + LIN_W'(nx_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            rotation_reg <= 2'd0;
            clr_cnt_reg  <= '0;
            walk_v_reg   <= 1'b0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_WIDTH:    width_reg    <= cfg_data;
                    REG_HEIGHT:   height_reg   <= cfg_data;
                    REG_ROTATION: rotation_reg <= cfg_data[1:0];
                    default:      ;
                endcase
            end
            if (cmd.clear_wr)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.load)
            begin
                walk_v_reg <= nonempty;
                s1_v_reg   <= 1'b0;
                s2_v_reg   <= 1'b0;
            end
            else if (cmd.advance)
            begin
                if (walk_v_reg && px_reg == x_last_reg && py_reg == y_last_reg)
                    walk_v_reg <= 1'b0;
                s1_v_reg <= walk_v_reg;
                s2_v_reg <= s1_v_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg    <= command;
            ink_reg    <= ink;
            addr_reg   <= byte_address;
            x0_reg     <= x0s[COORD_W-1:0];
            px_reg     <= x0s[COORD_W-1:0];
            py_reg     <= y0s[COORD_W-1:0];
            x_last_reg <= x1s[COORD_W-1:0] - 10'd1;
            y_last_reg <= y1s[COORD_W-1:0] - 10'd1;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd.advance)
            begin
                // Step the walker, then shift the map and address stages
                if (px_reg == x_last_reg)
                begin
                    px_reg <= x0_reg;
                    py_reg <= py_reg + 10'd1;
                end
                else
                    px_reg <= px_reg + 10'd1;
                nx_reg      <= nx_next;
                ny_reg      <= ny_next;
                s2_idx_reg  <= lin[ADDR_W+2:3];
                s2_ok_reg   <= (lin[LIN_W-1:ADDR_W+3] == '0);
                s2_mask_reg <= PIX_MSB_MASK >> nx_reg[2:0];
            end
            if (cmd.pix_wr && s2_ok_reg)
                count_reg <= count_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_data_reg  <= (cmd_reg == CMD_READ) ? (rdata_reg ^ BYTE_ONES) : 8'd0;
            out_count_reg <= count_reg;
        end
    end

    // Frame store: clear sweep, read-modify-write, byte read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
            mem[clr_cnt_reg] <= 8'd0;
        else if (cmd.pix_wr && s2_ok_reg)
            mem[s2_idx_reg] <= ink_reg ? (rdata_reg | s2_mask_reg)
                                       : (rdata_reg & ~s2_mask_reg);
        if (cmd.pix_rd)
            rdata_reg <= mem[s2_idx_reg];
        else if (cmd.byte_rd)
            rdata_reg <= mem[addr_reg];
    end

    assign stat.clear_last = &clr_cnt_reg;
    assign stat.s2_valid   = s2_v_reg;
    assign read_data       = out_data_reg;
    assign pixels_painted  = out_count_reg;

endmodule

// ===== sv/mfb_checker.sv =====
`include "assert_macros.svh"

module mfb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  read_data,
    input logic [18:0] pixels_painted
);

    // A stalled result holds its fields
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(pixels_painted))

    // One item at a time: ready drops right after an accept
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

    // A result carries read data or a paint count, never both
    `ASSERT_IMPL(a_exclusive_fields, clk, rst_n, out_valid, read_data == 8'd0 || pixels_painted == 19'd0)

    // A new result never appears in the cycle right after an accept
    `ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind mono_framebuffer_plotter mfb_checker u_mfb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .pixels_painted (pixels_painted)
);

// ===== verif/mono_framebuffer_plotter_tb.sv =====
module mono_framebuffer_plotter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfb_pkg::*;

    // Command code that the block does not act on; it still returns an empty result
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [10:0]        w;
        logic [10:0]        h;
        logic               ink;
        logic [14:0]        addr;
    } plot_item_t;

    typedef struct packed {
        logic [7:0]  rd;
        logic [18:0] pp;
    } plot_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic [1:0]   reg_idx;
        logic [9:0]   reg_val;
        plot_item_t   item;
        bit           typed;
        plot_result_t want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic [1:0]         cfg_index;
    logic [9:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [10:0]        rect_width;
    logic [10:0]        rect_height;
    logic               ink;
    logic [14:0]        byte_address;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         read_data;
    logic [18:0]        pixels_painted;

    // Mirror of the frame store and the panel registers
    logic [7:0]   frame_model [STORE_BYTES];
    int           cfg_width;
    int           cfg_height;
    logic [1:0]   cfg_rot;
    logic [15:0]  walk_col_m;
    logic [15:0]  walk_row_m;
    int           last_touched;

    plot_result_t awaited_results [$];
    plot_result_t oldest;
    int           mismatches = 0;
    bit           bursts_on = 1'b1;

    mono_framebuffer_plotter i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Set or clear one logical pixel; return 1 when it lands in the store
    function automatic bit paint_pixel(int x, int y, bit k);
        int lw, lh, nx, ny, lin, idx;
        logic [7:0] mask;
        lw = cfg_rot[0] ? cfg_height : cfg_width;
        lh = cfg_rot[0] ? cfg_width : cfg_height;
        if (x < 0 || y < 0 || x >= lw || y >= lh)
            return 1'b0;
        case (cfg_rot)
            2'd1:
            begin
                nx = cfg_width - 1 - y;
                ny = x;
            end
            2'd2:
            begin
                nx = cfg_width - 1 - x;
                ny = cfg_height - 1 - y;
            end
            2'd3:
            begin
                nx = y;
                ny = cfg_height - 1 - x;
            end
            default:
            begin
                nx = x;
                ny = y;
            end
        endcase
        if (nx < 0 || ny < 0 || nx >= cfg_width || ny >= cfg_height)
            return 1'b0;
        lin = nx + ny * cfg_width;
        idx = lin >> 3;
        if (idx >= STORE_BYTES)
            return 1'b0;
        mask = PIX_MSB_MASK >> (nx & 7);
        if (k)
            frame_model[idx] = frame_model[idx] | mask;
        else
            frame_model[idx] = frame_model[idx] & ~mask;
        last_touched = idx;
        return 1'b1;
    endfunction

    // Apply one command to the mirror and return the result it must produce
    function automatic plot_result_t apply_command(plot_item_t it);
        plot_result_t r;
        int x0, y0, x1, y1, lw, lh, cx, cy;
        r = '0;
        case (it.cmd)
            CMD_PIXEL:
                r.pp = paint_pixel(it.px, it.py, it.ink);
            CMD_RECT:
            begin
                lw = cfg_rot[0] ? cfg_height : cfg_width;
                lh = cfg_rot[0] ? cfg_width : cfg_height;
                x0 = (it.px < 0) ? 0 : int'(it.px);
                y0 = (it.py < 0) ? 0 : int'(it.py);
                x1 = int'(it.px) + int'(it.w);
                y1 = int'(it.py) + int'(it.h);
                if (x1 > lw)
                    x1 = lw;
                if (y1 > lh)
                    y1 = lh;
                for (cy = y0; cy < y1; cy++)
                begin
                    for (cx = x0; cx < x1; cx++)
                    begin
                        r.pp += paint_pixel(cx, cy, it.ink);
                        walk_col_m = cx[15:0];
                        walk_row_m = cy[15:0];
                    end
                end
            end
            CMD_READ:
                r.rd = frame_model[it.addr] ^ BYTE_ONES;
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic stim_row_t item_row(logic [1:0] c, int x, int y, int w, int h, bit k,
                                           int a, bit typed = 1'b0, logic [7:0] rd = '0,
                                           logic [18:0] pp = '0);
        stim_row_t row;
        row.kind      = ROW_ITEM;
        row.reg_idx   = REG_WIDTH;
        row.reg_val   = '0;
        row.item.cmd  = c;
        row.item.px   = 16'(x);
        row.item.py   = 16'(y);
        row.item.w    = 11'(w);
        row.item.h    = 11'(h);
        row.item.ink  = k;
        row.item.addr = 15'(a);
        row.typed     = typed;
        row.want.rd   = rd;
        row.want.pp   = pp;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [1:0] idx, logic [9:0] val);
        stim_row_t row;
        row = item_row(CMD_UNUSED, 0, 0, 0, 0, 1'b0, 0);
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // Random command, biased toward coordinates near the visible area
    function automatic plot_item_t random_item();
        plot_item_t it;
        int lw, lh, pick, nx, ny, a;
        lw = cfg_rot[0] ? cfg_height : cfg_width;
        lh = cfg_rot[0] ? cfg_width : cfg_height;
        pick = $urandom_range(0, 99);
        it.cmd = (pick < 35) ? CMD_PIXEL : (pick < 75) ? CMD_RECT :
                 (pick < 95) ? CMD_READ : CMD_UNUSED;
        if ($urandom_range(0, 6) == 0)
        begin
            it.px = 16'($urandom_range(0, 65535));
            it.py = 16'($urandom_range(0, 65535));
        end
        else
        begin
            it.px = 16'($urandom_range(0, lw + 15) - 8);
            it.py = 16'($urandom_range(0, lh + 15) - 8);
        end
        // Mostly small boxes; now and then a long thin line
        if ($urandom_range(0, 6) == 0)
        begin
            if ($urandom_range(0, 1))
            begin
                it.w = 11'($urandom_range(0, 1024));
                it.h = 11'($urandom_range(0, 2));
            end
            else
            begin
                it.w = 11'($urandom_range(0, 2));
                it.h = 11'($urandom_range(0, 1024));
            end
        end
        else
        begin
            it.w = 11'($urandom_range(0, 16));
            it.h = 11'($urandom_range(0, 16));
        end
        it.ink = 1'($urandom_range(0, 1));
        // Read near recent writes so stored bits are actually seen
        pick = $urandom_range(0, 9);
        a = $urandom_range(0, STORE_BYTES - 1);
        if (pick < 4)
        begin
            a = last_touched + $urandom_range(0, 2) - 1;
        end
        else if (pick < 7 && cfg_width > 0 && cfg_height > 0)
        begin
            nx = $urandom_range(0, cfg_width - 1);
            ny = $urandom_range(0, cfg_height - 1);
            if (((nx + ny * cfg_width) >> 3) < STORE_BYTES)
                a = (nx + ny * cfg_width) >> 3;
        end
        it.addr = 15'(a);
        return it;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [9:0] val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_WIDTH:    cfg_width = val;
            REG_HEIGHT:   cfg_height = val;
            REG_ROTATION: cfg_rot = val[1:0];
            default:      ;
        endcase
    endtask

    // Drop valid and hold until every awaited result is back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_item(plot_item_t it, bit typed, plot_result_t want);
        int gap;
        plot_result_t r;
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        command      <= it.cmd;
        pos_x        <= it.px;
        pos_y        <= it.py;
        rect_width   <= it.w;
        rect_height  <= it.h;
        ink          <= it.ink;
        byte_address <= it.addr;
        do
            @(posedge clk);
        while (!in_ready);
        r = apply_command(it);
        if (typed)
            r = want;
        awaited_results.push_back(r);
    endtask

    // Result side: random stall bursts
    initial
    begin
        int stall;
        out_ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest awaited one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result with none awaited, pixels_painted", pixels_painted, 0);
            end
            else
            begin
                oldest = awaited_results.pop_front();
                if (read_data !== oldest.rd)
                    report_mismatch("read_data", read_data, oldest.rd);
                if (pixels_painted !== oldest.pp)
                    report_mismatch("pixels_painted", pixels_painted, oldest.pp);
            end
        end
    end

    initial
    begin
        stim_row_t    rows [$];
        plot_result_t none;
        logic [9:0]   w_val, h_val;
        int           phase, pick;

        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        command      = CMD_PIXEL;
        pos_x        = '0;
        pos_y        = '0;
        rect_width   = '0;
        rect_height  = '0;
        ink          = 1'b0;
        byte_address = '0;
        none         = '0;

        foreach (frame_model[i])
            frame_model[i] = 8'h00;
        cfg_width    = WIDTH_RESET;
        cfg_height   = HEIGHT_RESET;
        cfg_rot      = 2'd0;
        walk_col_m   = '0;
        walk_row_m   = '0;
        last_touched = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // Wait out the store sweep
        do
            @(posedge clk);
        while (!in_ready);

        // Directed: reset state, edges, clipping, each rotation, full panel
        rows.push_back(item_row(CMD_READ, 0, 0, 0, 0, 1'b0, 0, 1'b1, BYTE_ONES, 0));
        rows.push_back(item_row(CMD_READ, 0, 0, 0, 0, 1'b0, 32767, 1'b1, BYTE_ONES, 0));
        rows.push_back(item_row(CMD_PIXEL, 0, 0, 0, 0, 1'b1, 0, 1'b1, 8'h00, 1));
        rows.push_back(item_row(CMD_READ, 0, 0, 0, 0, 1'b0, 0, 1'b1, 8'h7F, 0));
        rows.push_back(item_row(CMD_PIXEL, -32768, 32767, 0, 0, 1'b1, 0, 1'b1, 8'h00, 0));
        rows.push_back(item_row(CMD_PIXEL, 295, 127, 0, 0, 1'b1, 0));
        rows.push_back(item_row(CMD_PIXEL, 296, 0, 0, 0, 1'b1, 0, 1'b1, 8'h00, 0));
        rows.push_back(item_row(CMD_RECT, 5, 5, 0, 7, 1'b1, 0, 1'b1, 8'h00, 0));
        rows.push_back(item_row(CMD_RECT, 5, 5, 7, 0, 1'b1, 0, 1'b1, 8'h00, 0));
        rows.push_back(item_row(CMD_RECT, -3, -2, 5, 4, 1'b1, 0));
        rows.push_back(item_row(CMD_RECT, 10, 0, 1, 128, 1'b1, 0, 1'b1, 8'h00, 128));
        rows.push_back(item_row(CMD_RECT, 0, 10, 296, 1, 1'b0, 0, 1'b1, 8'h00, 296));
        rows.push_back(item_row(CMD_RECT, 32767, 32767, 1024, 1024, 1'b1, 0,
                                1'b1, 8'h00, 0));
        rows.push_back(item_row(CMD_RECT, 280, 120, 1024, 1024, 1'b1, 0));
        rows.push_back(item_row(CMD_PIXEL, 0, 0, 0, 0, 1'b0, 0));
        rows.push_back(item_row(CMD_READ, 0, 0, 0, 0, 1'b0, 0));
        rows.push_back(item_row(CMD_UNUSED, -1, -1, 2047, 2047, 1'b1, 32767,
                                1'b1, 8'h00, 0));
        rows.push_back(cfg_row(REG_ROTATION, 10'd1));
        rows.push_back(item_row(CMD_PIXEL, 0, 0, 0, 0, 1'b1, 0));
        rows.push_back(item_row(CMD_READ, 0, 0, 0, 0, 1'b0, 36));
        rows.push_back(cfg_row(REG_ROTATION, 10'd2));
        rows.push_back(item_row(CMD_PIXEL, 0, 0, 0, 0, 1'b1, 0));
        rows.push_back(item_row(CMD_READ, 0, 0, 0, 0, 1'b0, 4735));
        rows.push_back(cfg_row(REG_ROTATION, 10'd3));
        rows.push_back(item_row(CMD_PIXEL, 0, 0, 0, 0, 1'b1, 0));
        rows.push_back(item_row(CMD_READ, 0, 0, 0, 0, 1'b0, 4699));
        rows.push_back(cfg_row(REG_WIDTH, 10'd512));
        rows.push_back(cfg_row(REG_HEIGHT, 10'd512));
        rows.push_back(cfg_row(REG_ROTATION, 10'd0));
        rows.push_back(item_row(CMD_RECT, 0, 0, 1024, 1024, 1'b1, 0, 1'b1, 8'h00, 262144));
        rows.push_back(item_row(CMD_READ, 0, 0, 0, 0, 1'b0, 32767, 1'b1, 8'h00, 0));

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end
            else
            begin
                send_item(rows[i].item, rows[i].typed, rows[i].want);
            end
        end

        // Random: one panel setting per phase, smallest and largest first
        for (phase = 0; phase < 8; phase++)
        begin
            drain_results();
            bursts_on = (phase != 3 && phase != 7);
            if (phase == 0)
            begin
                w_val = 10'd8;
                h_val = 10'd1;
            end
            else if (phase == 1)
            begin
                w_val = 10'd1023;
                h_val = 10'd1023;
            end
            else
            begin
                pick = $urandom_range(0, 9);
                w_val = 10'((pick == 0) ? 512 : (pick == 1) ? $urandom_range(513, 1023) :
                            (pick == 2) ? $urandom_range(0, 1023) :
                            8 * $urandom_range(1, 64));
                pick = $urandom_range(0, 9);
                h_val = 10'((pick == 0) ? 512 : (pick == 1) ? $urandom_range(513, 1023) :
                            (pick == 2) ? $urandom_range(0, 1023) :
                            $urandom_range(1, 512));
            end
            write_reg(REG_WIDTH, w_val);
            write_reg(REG_HEIGHT, h_val);
            write_reg(REG_ROTATION, 10'(phase % 4));
            repeat (116) send_item(random_item(), 1'b0, none);
        end

        drain_results();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
